### rtl/stable_insertion_sorter_unit_defines.svh
// Assertion macros for the sorter's port checker.
// Each expects clk and arst_n in scope.
`ifndef STABLE_INSERTION_SORTER_UNIT_DEFINES_SVH
`define STABLE_INSERTION_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SIS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sis_pkg.sv
package sis_pkg;

	localparam int unsigned FIELD_BITS = 32;

	typedef struct packed {
		logic [FIELD_BITS-1:0] key;
		logic [FIELD_BITS-1:0] payload;
		logic                  last_element;
	} record_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] sorted_key;
		logic [FIELD_BITS-1:0] sorted_payload;
		logic                  final_record;
		logic                  overflowed;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_EMIT
	} state_t;

endpackage

### rtl/sis_chan_if.sv
interface sis_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/stable_insertion_sorter_unit.sv
// Stable insertion sorter. Records (key, payload) arrive one item at a time on
// records and are kept in ascending unsigned key order in two one-port-read
// synchronous memories (keys and payloads, MAX_RECORDS deep). A record with a
// key equal to stored ones lands after them, so ties keep arrival order. The
// item flagged last_element is inserted too, then every stored record goes
// out on sorted in order, the final one marked final_record, and the store
// empties. Records arriving while the store is full are dropped and every
// result of that set carries overflowed. Flow: records.ready is high only
// while the block is idle. An item into an empty store is written straight
// to the head, one into a full one is dropped. Otherwise the tail is read,
// then one record moves up per cycle while its key is greater, the next read
// overlapping the current write-back, and the item is written into the gap.
// Emission issues each read only after the last one has landed and when the
// output register will be free; a result waits there while the sink stalls.
// No clearing pass after reset: entries are only read below the fill count.
module stable_insertion_sorter_unit #(
	parameter int unsigned MAX_RECORDS  = 64,
	parameter int unsigned KEY_BITS     = 32,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	sis_chan_if.sink   records,
	sis_chan_if.source sorted
);

	localparam int unsigned AW = $clog2(MAX_RECORDS);
	localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

	// Record store
	logic [KEY_BITS-1:0]     key_mem [MAX_RECORDS];
	logic [PAYLOAD_BITS-1:0] pay_mem [MAX_RECORDS];
	logic [KEY_BITS-1:0]     rd_key_q;
	logic [PAYLOAD_BITS-1:0] rd_pay_q;

	// Control state
	sis_pkg::state_t state_q, nxt;
	logic [CW-1:0]   count_q;
	logic            dropped_q;
	logic [AW-1:0]   idx_q;
	logic            pend_s1;
	logic            ov_q;

	// Record being inserted
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic                    last_q;
	logic [AW-1:0]           pos_q;

	// Emission pipeline and output register
	logic              final_s1;
	logic              ovf_s1;
	sis_pkg::result_t  out_q;

	// Decoded control
	logic                    in_ready;
	logic                    we;
	logic [AW-1:0]           wa;
	logic [KEY_BITS-1:0]     wkey;
	logic [PAYLOAD_BITS-1:0] wpay;
	logic                    re;
	logic [AW-1:0]           ra;
	logic                    load_in;
	logic                    pos_dec;
	logic                    cnt_inc;
	logic                    drop_set;
	logic                    issue;
	logic                    issue_last;

	logic [KEY_BITS-1:0]     key_in;
	logic [PAYLOAD_BITS-1:0] pay_in;
	logic [CW-1:0]           cnt_m1;
	logic                    full;

	// Keep only the low KEY_BITS / PAYLOAD_BITS bits, zero-extend when wider.
	assign key_in = KEY_BITS'(records.data.key);
	assign pay_in = PAYLOAD_BITS'(records.data.payload);
	assign cnt_m1 = count_q - CW'(1);
	assign full   = (count_q == CW'(MAX_RECORDS));

	assign records.ready = in_ready;
	assign sorted.valid  = ov_q;
	assign sorted.data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sis_pkg::ST_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt        = state_q;
		in_ready   = 1'b0;
		we         = 1'b0;
		wa         = pos_q;
		wkey       = key_q;
		wpay       = pay_q;
		re         = 1'b0;
		ra         = idx_q;
		load_in    = 1'b0;
		pos_dec    = 1'b0;
		cnt_inc    = 1'b0;
		drop_set   = 1'b0;
		issue      = 1'b0;
		issue_last = 1'b0;
		case (state_q)
			sis_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (records.valid) begin
					if (full) begin
						// drop the record, still flush on last
						drop_set = 1'b1;
						if (records.data.last_element) begin
							nxt = sis_pkg::ST_EMIT;
						end
					end else if (count_q == '0) begin
						// empty store: write straight to the head
						we      = 1'b1;
						wa      = '0;
						wkey    = key_in;
						wpay    = pay_in;
						cnt_inc = 1'b1;
						if (records.data.last_element) begin
							nxt = sis_pkg::ST_EMIT;
						end
					end else begin
						// fetch the current tail to start the shift
						load_in = 1'b1;
						re      = 1'b1;
						ra      = cnt_m1[AW-1:0];
						nxt     = sis_pkg::ST_SHIFT;
					end
				end
			end
			sis_pkg::ST_SHIFT: begin
				// rd holds entry pos-1; strictly greater moves up, equal stays
				if (rd_key_q > key_q) begin
					we      = 1'b1;
					wa      = pos_q;
					wkey    = rd_key_q;
					wpay    = rd_pay_q;
					pos_dec = 1'b1;
					if (pos_q == AW'(1)) begin
						nxt = sis_pkg::ST_PLACE;
					end else begin
						re = 1'b1;
						ra = pos_q - AW'(2);
					end
				end else begin
					we      = 1'b1;
					cnt_inc = 1'b1;
					nxt     = last_q ? sis_pkg::ST_EMIT : sis_pkg::ST_IDLE;
				end
			end
			sis_pkg::ST_PLACE: begin
				we      = 1'b1;
				cnt_inc = 1'b1;
				nxt     = last_q ? sis_pkg::ST_EMIT : sis_pkg::ST_IDLE;
			end
			sis_pkg::ST_EMIT: begin
				// read only when the output register is free by the time data lands
				if (!pend_s1 && (!ov_q || sorted.ready)) begin
					re    = 1'b1;
					ra    = idx_q;
					issue = 1'b1;
					if (CW'(idx_q) == cnt_m1) begin
						issue_last = 1'b1;
						nxt        = sis_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				nxt = sis_pkg::ST_IDLE;
			end
		endcase
	end

	// Store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[wa] <= wkey;
			pay_mem[wa] <= wpay;
		end
		if (re) begin
			rd_key_q <= key_mem[ra];
			rd_pay_q <= pay_mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			idx_q     <= '0;
			pend_s1   <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			// clear the set once its final read is issued
			if (issue_last) begin
				count_q <= '0;
			end else if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (issue_last) begin
				dropped_q <= 1'b0;
			end else if (drop_set) begin
				dropped_q <= 1'b1;
			end
			if (issue_last) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + AW'(1);
			end
			pend_s1 <= issue;
			if (pend_s1) begin
				ov_q <= 1'b1;
			end else if (sorted.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			key_q  <= key_in;
			pay_q  <= pay_in;
			last_q <= records.data.last_element;
			pos_q  <= count_q[AW-1:0];
		end else if (pos_dec) begin
			pos_q <= pos_q - AW'(1);
		end
		if (issue) begin
			final_s1 <= issue_last;
			ovf_s1   <= dropped_q;
		end
		if (pend_s1) begin
			out_q.sorted_key     <= sis_pkg::FIELD_BITS'(rd_key_q);
			out_q.sorted_payload <= sis_pkg::FIELD_BITS'(rd_pay_q);
			out_q.final_record   <= final_s1;
			out_q.overflowed     <= ovf_s1;
		end
	end

endmodule

### rtl/sis_port_checker.sv
`include "stable_insertion_sorter_unit_defines.svh"

module sis_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready
);

	// a stalled result stays offered
	`SIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// the read port does not refill the output register in the cycle after a take
	`SIS_ASSERT_NEXT(a_out_gap, out_valid && out_ready, !out_valid, "result refilled too early")

	// a closing item always starts insertion or emission, never back-to-back input
	`SIS_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_last, !in_ready,
		"input taken right after the last item of a set")

endmodule

bind stable_insertion_sorter_unit sis_port_checker u_sis_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (records.valid),
	.in_ready  (records.ready),
	.in_last   (records.data.last_element),
	.out_valid (sorted.valid),
	.out_ready (sorted.ready)
);

### verif/sorted_order_checker.sv
`timescale 1ns / 1ps

module sorted_order_checker
	import sis_pkg::*;
#(
	parameter int unsigned MAX_RECORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_valid,
	input  logic        rec_ready,
	input  record_t     rec_data,
	input  logic        res_valid,
	input  logic        res_ready,
	input  result_t     res_data,
	output int unsigned fail_count,
	output int unsigned results_pending
);

	// Shadow copy of the block's store, kept in ascending key order.
	logic [FIELD_BITS-1:0] shadow_keys     [MAX_RECORDS];
	logic [FIELD_BITS-1:0] shadow_payloads [MAX_RECORDS];
	int unsigned           shadow_count = 0;
	logic                  shadow_dropped = 1'b0;
	int unsigned           mismatches = 0;
	result_t               predicted_sorted [$];

	// Insert one record after every equal key, or drop it when full; release the whole set on its last item.
	task automatic file_record(input record_t rec);
		int unsigned slot;
		result_t     out_rec;
		if (shadow_count >= MAX_RECORDS) begin
			shadow_dropped = 1'b1;
		end else begin
			slot = shadow_count;
			while (slot > 0 && shadow_keys[slot-1] > rec.key) begin
				shadow_keys[slot]     = shadow_keys[slot-1];
				shadow_payloads[slot] = shadow_payloads[slot-1];
				slot--;
			end
			shadow_keys[slot]     = rec.key;
			shadow_payloads[slot] = rec.payload;
			shadow_count++;
		end
		if (rec.last_element) begin
			for (int unsigned i = 0; i < shadow_count; i++) begin
				out_rec.sorted_key     = shadow_keys[i];
				out_rec.sorted_payload = shadow_payloads[i];
				out_rec.final_record   = (i + 1 == shadow_count);
				out_rec.overflowed     = shadow_dropped;
				predicted_sorted.push_back(out_rec);
			end
			shadow_count   = 0;
			shadow_dropped = 1'b0;
		end
	endtask

	task automatic compare_result(input result_t got);
		result_t want;
		if (predicted_sorted.size() == 0) begin
			$display("%0t: unexpected result: key %h payload %h final %b overflowed %b",
				$time, got.sorted_key, got.sorted_payload, got.final_record, got.overflowed);
			mismatches++;
		end else begin
			want = predicted_sorted.pop_front();
			if (got.sorted_key !== want.sorted_key) begin
				$display("%0t: sorted_key mismatch: expected %h, actual %h",
					$time, want.sorted_key, got.sorted_key);
				mismatches++;
			end
			if (got.sorted_payload !== want.sorted_payload) begin
				$display("%0t: sorted_payload mismatch: expected %h, actual %h",
					$time, want.sorted_payload, got.sorted_payload);
				mismatches++;
			end
			if (got.final_record !== want.final_record) begin
				$display("%0t: final_record mismatch: expected %b, actual %b",
					$time, want.final_record, got.final_record);
				mismatches++;
			end
			if (got.overflowed !== want.overflowed) begin
				$display("%0t: overflowed mismatch: expected %b, actual %b",
					$time, want.overflowed, got.overflowed);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count    = 0;
			shadow_dropped  = 1'b0;
			predicted_sorted.delete();
			results_pending <= 0;
			fail_count      <= mismatches;
		end else begin
			if (res_valid && res_ready) begin
				compare_result(res_data);
			end
			if (rec_valid && rec_ready) begin
				file_record(rec_data);
			end
			results_pending <= predicted_sorted.size();
			fail_count      <= mismatches;
		end
	end

endmodule

### verif/tb_stable_insertion_sorter_unit.sv
`timescale 1ns / 1ps

module tb_stable_insertion_sorter_unit;
	import sis_pkg::*;

	localparam int unsigned MAX_RECORDS      = 64;
	localparam int unsigned RANDOM_ITEMS     = 420;
	// Longest quiet stretch: a full-store insertion, the long receiver
	// hold-off and a sender gap, taken several times over.
	localparam int unsigned QUIET_LIMIT      = 5000;
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES    = 80;

	// Receiver stall patterns, taken in turn as drain_cycle advances.
	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_SPARSE,
		DRAIN_EVERY_THIRD
	} drain_mode_t;

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned results_pending;

	sis_chan_if #(.payload_t(record_t)) rec_if ();
	sis_chan_if #(.payload_t(result_t)) res_if ();

	stable_insertion_sorter_unit #(
		.MAX_RECORDS (MAX_RECORDS),
		.KEY_BITS    (FIELD_BITS),
		.PAYLOAD_BITS(FIELD_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.records(rec_if),
		.sorted (res_if)
	);

	sorted_order_checker #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (rec_if.valid),
		.rec_ready      (rec_if.ready),
		.rec_data       (rec_if.data),
		.res_valid      (res_if.valid),
		.res_ready      (res_if.ready),
		.res_data       (res_if.data),
		.fail_count     (fail_count),
		.results_pending(results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Receiver: its own stall pattern, plus a long hold-off on request.
	// The sender bumps hold_off_req; the receiver notices the change on
	// the next edge and holds ready low until hold_left, loaded with LONG_HOLD_CYCLES, runs out.
	// ------------------------------------------------------------------
	int unsigned hold_off_req = 0;
	int unsigned hold_seen    = 0;
	int unsigned hold_left    = 0;
	int unsigned drain_cycle  = 0;

	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			drain_cycle++;
			if (hold_off_req != hold_seen) begin
				hold_seen = hold_off_req;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				case (drain_mode_t'((drain_cycle / 256) % 4))
					DRAIN_FREE: begin
						res_if.ready <= 1'b1;
					end
					DRAIN_COIN: begin
						res_if.ready <= ($urandom_range(0, 1) == 1);
					end
					DRAIN_SPARSE: begin
						res_if.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						res_if.ready <= (drain_cycle % 3 == 0);
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if neither channel moves an item for too long.
	// ------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((rec_if.valid && rec_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("stable_insertion_sorter_unit regression: fail");
				$finish;
			end
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sender.
	// ------------------------------------------------------------------
	int unsigned burst_left = 0;
	int unsigned random_sent = 0;

	// Offer one item and hold it until accepted. Bursts of random length are
	// separated by random gaps; a long burst gives stretches with no idling.
	task automatic offer_record(input logic [FIELD_BITS-1:0] key_val,
			input logic [FIELD_BITS-1:0] payload_val, input logic is_last);
		record_t rec;
		rec.key          = key_val;
		rec.payload      = payload_val;
		rec.last_element = is_last;
		if (burst_left == 0) begin
			rec_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		rec_if.valid <= 1'b1;
		rec_if.data  <= rec;
		@(posedge clk);
		while (!rec_if.ready) @(posedge clk);
		burst_left--;
	endtask

	// Stop offering and wait until every predicted result has come out, then
	// let the block settle before the next item.
	task automatic wait_for_drain();
		rec_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Keys lean toward a tiny range so ties are common, with extremes mixed in.
	function automatic logic [FIELD_BITS-1:0] pick_key();
		logic [FIELD_BITS-1:0] k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: k = $urandom_range(0, 3);
			4: begin
				case ($urandom_range(0, 3))
					0: k = '0;
					1: k = '1;
					2: k = 32'h8000_0000;
					default: k = 32'h7FFF_FFFF;
				endcase
			end
			5: k = 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: k = $urandom;
		endcase
		return k;
	endfunction

	// Send one set of the given size with random content; the final item
	// carries last_element. Sizes above MAX_RECORDS overflow the store.
	task automatic send_set(input int unsigned set_size);
		for (int unsigned i = 0; i < set_size; i++) begin
			offer_record(pick_key(), $urandom, i + 1 == set_size);
			random_sent++;
		end
	endtask

	initial begin
		int unsigned set_no;
		int unsigned set_size;

		arst_n       <= 1'b0;
		rec_if.valid <= 1'b0;
		rec_if.data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a one-record set into the empty store.
		offer_record(32'h0000_0000, 32'h0000_0000, 1'b1);

		// Directed: key extremes, ties at both ends, payload extremes.
		offer_record(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		offer_record(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
		offer_record(32'h0000_0000, 32'h0000_0002, 1'b0);
		offer_record(32'h8000_0000, 32'h0000_0003, 1'b0);
		offer_record(32'h0000_0000, 32'h0000_0004, 1'b0);
		offer_record(32'h7FFF_FFFF, 32'h0000_0005, 1'b0);
		offer_record(32'hFFFF_FFFF, 32'h0000_0006, 1'b1);

		// Directed: strictly descending keys, every insertion lands at the head.
		offer_record(32'd5, 32'h1111_1111, 1'b0);
		offer_record(32'd4, 32'h2222_2222, 1'b0);
		offer_record(32'd3, 32'h3333_3333, 1'b0);
		offer_record(32'd2, 32'h4444_4444, 1'b0);
		offer_record(32'd1, 32'h5555_5555, 1'b1);

		// Directed: all keys equal, arrival order must survive.
		offer_record(32'h5A5A_A5A5, 32'hA5A5_5A5A, 1'b0);
		offer_record(32'h5A5A_A5A5, 32'h5A5A_A5A5, 1'b0);
		offer_record(32'h5A5A_A5A5, 32'h0000_0000, 1'b0);
		offer_record(32'h5A5A_A5A5, 32'hFFFF_FFFF, 1'b1);

		wait_for_drain();

		// Random sets: mostly short, a few that fill or overflow the store.
		set_no = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (set_no)
				2: set_size = MAX_RECORDS;          // exactly full, no drop
				5: set_size = MAX_RECORDS + 1;      // the last item itself is dropped
				9: set_size = MAX_RECORDS + 6;      // several drops before the last
				default: begin
					set_size = ($urandom_range(0, 24) == 0)
						? $urandom_range(MAX_RECORDS - 4, MAX_RECORDS + 4)
						: $urandom_range(1, 8);
				end
			endcase
			send_set(set_size);

			if (set_no == 2) begin
				// Hold the receiver off while the full set drains and keep
				// offering the next set, so the block backs up into its input.
				hold_off_req <= hold_off_req + 1;
				burst_left = MAX_RECORDS;
			end else if (set_no == 5 || $urandom_range(0, 5) == 0) begin
				wait_for_drain();
			end
			set_no++;
		end
		rec_if.valid <= 1'b0;

		// Drain, then give the block time to show any stray result.
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && results_pending == 0) begin
			$display("stable_insertion_sorter_unit regression: pass");
		end else begin
			$display("stable_insertion_sorter_unit regression: fail");
		end
		$finish;
	end

endmodule
